// File: hdl/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;

  localparam int NUM_STACKS_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 128;

  localparam int CNT_W  = 8;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int STS_W  = 2;
  localparam int SIU_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STS_W-1:0] ST_INVALID   = 2'd3;

  localparam logic REG_STACKS_IN_USE = 1'b0;

  localparam logic [SIU_W-1:0] STACKS_IN_USE_RST = 5'd16;

endpackage

// File: hdl/mse_count_mem.sv
`timescale 1ns / 1ps
module mse_count_mem
  import mse_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int CNT_AW     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [CNT_AW-1:0] rd_addr,
  output logic [CNT_W-1:0]  rd_count,
  input  logic              wr_en,
  input  logic [CNT_AW-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_data
);

  logic [CNT_W-1:0]      cnt_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] valid_r;
  logic [CNT_W-1:0]      rd_data_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= cnt_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // unwritten entry reads as empty
  assign rd_count = rd_valid_r ? rd_data_r : '0;

endmodule

// File: hdl/mse_elem_mem.sv
`timescale 1ns / 1ps
module mse_elem_mem
  import mse_pkg::*;
#(
  parameter int DEPTH = NUM_STACKS_DEF * STACK_DEPTH_DEF,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/multi_stack_engine.sv
`timescale 1ns / 1ps
// Bank of NUM_STACKS independent LIFO stacks of STACK_DEPTH 32-bit words each.
// Command channel: drive in_cmd (push, pop, peek), in_stack_index and
// in_push_value with start high; the command is taken at a clock edge where
// busy is low. Each command yields one result: out_status and
// out_read_value are shown for one cycle with out_valid high.
// The command then passes through states S_CNT and S_MEM before the result
// strobe; busy stays high while it is in those states.
// A new command is taken only once the last one is through the fill-count
// memory read, then the element memory access, then the output register.
// The receiver cannot stall; a result is lost if not taken in its cycle.
// Configuration: APB register 0 (stacks_in_use) at byte address 0; write
// it only while idle. Counts above NUM_STACKS act as NUM_STACKS.
// Reset: all stacks empty at once (fill counts carry valid bits), no sweep;
// stacks_in_use returns to 16. Element storage is not cleared.
module multi_stack_engine
  import mse_pkg::*;
#(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [IDX_W-1:0]  in_stack_index,
  input  logic [DATA_W-1:0] in_push_value,
  output logic              out_valid,
  output logic [STS_W-1:0]  out_status,
  output logic [DATA_W-1:0] out_read_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CNT_AW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int ELEM_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int ELEM_AW    = $clog2(ELEM_DEPTH);
  localparam int LIM_W      = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CNT,
    S_MEM
  } state_t;

  state_t               state_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [IDX_W-1:0]     idx_r;
  logic [DATA_W-1:0]    val_r;
  logic [STS_W-1:0]     sts_r;
  logic                 rd_ok_r;
  logic                 out_valid_r;
  logic [STS_W-1:0]     out_status_r;
  logic [DATA_W-1:0]    out_read_value_r;
  logic [SIU_W-1:0]     stacks_in_use_r;

  logic                 accept;
  logic [CNT_W-1:0]     cnt;
  logic                 idx_invalid;
  logic                 is_push;
  logic                 is_read;
  logic [STS_W-1:0]     sts_nxt;
  logic                 cnt_wr_en;
  logic [CNT_W-1:0]     cnt_wr_data;
  logic                 elem_wr_en;
  logic                 elem_rd_en;
  logic [ELEM_AW-1:0]   elem_base;
  logic [CNT_W-1:0]     elem_off;
  logic [ELEM_AW-1:0]   elem_addr;
  logic [DATA_W-1:0]    elem_rd_data;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_in_use_r <= STACKS_IN_USE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STACKS_IN_USE)) begin
      stacks_in_use_r <= pwdata[SIU_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STACKS_IN_USE) ?
                  {{(APB_DW-SIU_W){1'b0}}, stacks_in_use_r} : '0;

  mse_count_mem #(
    .NUM_STACKS (NUM_STACKS),
    .CNT_AW     (CNT_AW)
  ) u_count_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (CNT_AW'(in_stack_index)),
    .rd_count (cnt),
    .wr_en    (cnt_wr_en),
    .wr_addr  (CNT_AW'(idx_r)),
    .wr_data  (cnt_wr_data)
  );

  always_comb begin
    idx_invalid = ({1'b0, idx_r} >= stacks_in_use_r) ||
                  (LIM_W'(idx_r) >= LIM_W'(NUM_STACKS));
    is_push     = 1'b0;
    is_read     = 1'b0;
    sts_nxt     = ST_OK;
    cnt_wr_data = cnt;
    case (cmd_r) inside
      CMD_PUSH: begin
        if (idx_invalid) begin
          sts_nxt = ST_INVALID;
        end else if (cnt >= CNT_W'(STACK_DEPTH)) begin
          sts_nxt = ST_OVERFLOW;
        end else begin
          is_push     = 1'b1;
          cnt_wr_data = cnt + 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (idx_invalid) begin
          sts_nxt = ST_INVALID;
        end else if (cnt == '0) begin
          sts_nxt = ST_UNDERFLOW;
        end else begin
          is_read = 1'b1;
          if (cmd_r == CMD_POP) begin
            cnt_wr_data = cnt - 1'b1;
          end
        end
      end
      default: begin
        sts_nxt = ST_OK;
      end
    endcase
  end

  assign cnt_wr_en  = (state_r == S_CNT) && (is_push || (is_read && (cmd_r == CMD_POP)));
  assign elem_wr_en = (state_r == S_CNT) && is_push;
  assign elem_rd_en = (state_r == S_CNT) && is_read;
  assign elem_base  = ELEM_AW'(idx_r) * ELEM_AW'(STACK_DEPTH);
  assign elem_off   = is_push ? cnt : (cnt - 1'b1);
  assign elem_addr  = elem_base + ELEM_AW'(elem_off);

  mse_elem_mem #(
    .DEPTH (ELEM_DEPTH),
    .AW    (ELEM_AW)
  ) u_elem_mem (
    .clk     (clk),
    .wr_en   (elem_wr_en),
    .rd_en   (elem_rd_en),
    .addr    (elem_addr),
    .wr_data (val_r),
    .rd_data (elem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_CNT;
            cmd_r   <= in_cmd;
            idx_r   <= in_stack_index;
            val_r   <= in_push_value;
          end
        end
        S_CNT: begin
          state_r <= S_MEM;
          sts_r   <= sts_nxt;
          rd_ok_r <= is_read;
        end
        S_MEM: begin
          state_r          <= S_IDLE;
          out_valid_r      <= 1'b1;
          out_status_r     <= sts_r;
          out_read_value_r <= rd_ok_r ? elem_rd_data : '0;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

endmodule
